// ===== rtl/wosc_pkg.sv =====
// Package for the wheel odometry speed controller.
// Holds item/result/config types, opcodes, reset values and the duty step helper.
// No dependencies.
package wosc_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned ItemDataW   = 48;
  localparam int unsigned ItemUserW   = 3;
  localparam int unsigned ResultDataW = 48;

  localparam logic [7:0] PulsesPerCmRst = 8'd80;
  localparam logic [7:0] PwmFloorRst    = 8'h20;
  localparam logic [7:0] PwmCeilingRst  = 8'hFA;
  localparam logic [7:0] StartPwmRst    = 8'h40;
  localparam logic [7:0] EndSpeedMaxRst = 8'd20;
  localparam logic [7:0] EndSpeedMinRst = 8'd2;

  typedef enum logic [2:0] {
    MODE_PULSE      = 3'd0,
    MODE_SPEED_TICK = 3'd1,
    MODE_RAMP_TICK  = 3'd2,
    MODE_MOVE       = 3'd3,
    MODE_SET_DIST   = 3'd4,
    MODE_NUDGE_UP   = 3'd5,
    MODE_NUDGE_DOWN = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSES_PER_CM = 3'd0,
    CFG_PWM_FLOOR     = 3'd1,
    CFG_PWM_CEILING   = 3'd2,
    CFG_START_PWM     = 3'd3,
    CFG_END_SPEED_MAX = 3'd4,
    CFG_END_SPEED_MIN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pulses_per_cm;
    logic [7:0] pwm_floor;
    logic [7:0] pwm_ceiling;
    logic [7:0] start_pwm;
    logic [7:0] end_speed_max;
    logic [7:0] end_speed_min;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic [1:0]         direction;
    logic [7:0]         start_speed;
    logic [7:0]         end_speed;
    logic [7:0]         ramp_slope;
    logic signed [15:0] target_cm;
  } item_t;

  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic               pwm_on;
    logic               arrived;
    logic [1:0]         direction_now;
    logic signed [15:0] distance_cm;
    logic [7:0]         measured_speed;
    logic [7:0]         speed_setpoint;
  } result_t;

  // duty step 1..4 from the gap a - b
  function automatic logic [2:0] step_size(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] diff;
    diff = a - b;
    if (diff > 8'd3)      step_size = 3'd4;
    else if (diff > 8'd2) step_size = 3'd3;
    else if (diff > 8'd1) step_size = 3'd2;
    else                  step_size = 3'd1;
  endfunction

endpackage

// ===== rtl/wosc_cfg_regs.sv =====
// Configuration register bank of the wheel odometry speed controller.
// Depends on wosc_pkg.
module wosc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wosc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wosc_pkg::CfgDataW-1:0] cfg_data_i,
  output wosc_pkg::cfg_t                cfg_o
);
  import wosc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulses_per_cm <= PulsesPerCmRst;
      cfg_q.pwm_floor     <= PwmFloorRst;
      cfg_q.pwm_ceiling   <= PwmCeilingRst;
      cfg_q.start_pwm     <= StartPwmRst;
      cfg_q.end_speed_max <= EndSpeedMaxRst;
      cfg_q.end_speed_min <= EndSpeedMinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PULSES_PER_CM: cfg_q.pulses_per_cm <= cfg_data_i;
        CFG_PWM_FLOOR:     cfg_q.pwm_floor     <= cfg_data_i;
        CFG_PWM_CEILING:   cfg_q.pwm_ceiling   <= cfg_data_i;
        CFG_START_PWM:     cfg_q.start_pwm     <= cfg_data_i;
        CFG_END_SPEED_MAX: cfg_q.end_speed_max <= cfg_data_i;
        CFG_END_SPEED_MIN: cfg_q.end_speed_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/wosc_core.sv =====
// Controller state and per-item update: odometry, speed sampling, duty regulation, ramp.
// Depends on wosc_pkg. One item is applied per fire_i.
module wosc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  wosc_pkg::item_t   item_i,
  input  wosc_pkg::cfg_t    cfg_i,
  output wosc_pkg::result_t result_o
);
  import wosc_pkg::*;

  logic [15:0] pulse_count_q, pulse_count_d;
  logic [15:0] last_pulse_q, last_pulse_d;
  logic [15:0] mark_q, mark_d;
  logic [7:0]  samples_q [2];
  logic [7:0]  samples_d [2];
  logic        slot_q, slot_d;
  logic [7:0]  avg_q, avg_d;
  logic [7:0]  setpoint_q, setpoint_d;
  logic [7:0]  goal_speed_q, goal_speed_d;
  logic [7:0]  slope_limit_q, slope_limit_d;
  logic [7:0]  slope_cnt_q, slope_cnt_d;
  logic [7:0]  duty_q, duty_d;
  dir_e        dir_q, dir_d;
  logic        hold_q, hold_d;
  logic [15:0] trav_q, trav_d;
  logic [15:0] goal_cm_q, goal_cm_d;
  logic        done_q, done_d;

  // odometry
  logic [15:0] pc_fwd, pc_rev, diff_fwd, diff_rev, trav_fwd, trav_rev;
  logic [16:0] ppc_ext, ppc_neg;
  logic        step_fwd, step_rev, arrive_fwd, arrive_rev;

  // speed sample
  logic [15:0] sdiff, smag;
  logic [7:0]  sat_fwd, sat_rev, new_s0, new_s1, avg_new;
  logic [8:0]  sum_s;
  logic [2:0]  step;
  logic [9:0]  duty_dn;
  logic [8:0]  duty_up;
  logic        dir_match;

  always_comb begin
    pc_fwd     = pulse_count_q + 16'd1;
    pc_rev     = pulse_count_q - 16'd1;
    diff_fwd   = pc_fwd - mark_q;
    diff_rev   = pc_rev - mark_q;
    ppc_ext    = {9'd0, cfg_i.pulses_per_cm};
    ppc_neg    = 17'd0 - ppc_ext;
    step_fwd   = $signed({diff_fwd[15], diff_fwd}) >= $signed(ppc_ext);
    step_rev   = $signed({diff_rev[15], diff_rev}) <= $signed(ppc_neg);
    trav_fwd   = trav_q + 16'd1;
    trav_rev   = trav_q - 16'd1;
    arrive_fwd = $signed(goal_cm_q) <= $signed(trav_fwd);
    arrive_rev = $signed(goal_cm_q) >= $signed(trav_rev);
  end

  always_comb begin
    sdiff   = pulse_count_q - last_pulse_q;
    smag    = 16'd0 - sdiff;
    sat_fwd = (sdiff[15:8] != 8'd0) ? 8'hFF : sdiff[7:0];
    sat_rev = (smag[15:8] != 8'd0) ? 8'hFF : smag[7:0];
    new_s0  = samples_q[0];
    new_s1  = samples_q[1];
    if (!hold_q && dir_q == DIR_FWD) begin
      if (!sdiff[15]) begin
        if (slot_q) new_s1 = sat_fwd;
        else        new_s0 = sat_fwd;
      end
    end else if (!hold_q && dir_q == DIR_REV) begin
      if (sdiff[15] || sdiff == 16'd0) begin
        if (slot_q) new_s1 = sat_rev;
        else        new_s0 = sat_rev;
      end
    end else begin
      if (slot_q) new_s1 = 8'd0;
      else        new_s0 = 8'd0;
    end
    sum_s   = {1'b0, new_s0} + {1'b0, new_s1};
    avg_new = sum_s[8:1];
    step    = (avg_new > setpoint_q) ? step_size(avg_new, setpoint_q)
                                     : step_size(setpoint_q, avg_new);
    duty_dn = {2'b00, duty_q} - {7'd0, step};
    duty_up = {1'b0, duty_q} + {6'd0, step};
  end

  assign dir_match = (dir_q == dir_e'(item_i.direction));

  always_comb begin
    pulse_count_d = pulse_count_q;
    last_pulse_d  = last_pulse_q;
    mark_d        = mark_q;
    samples_d[0]  = samples_q[0];
    samples_d[1]  = samples_q[1];
    slot_d        = slot_q;
    avg_d         = avg_q;
    setpoint_d    = setpoint_q;
    goal_speed_d  = goal_speed_q;
    slope_limit_d = slope_limit_q;
    slope_cnt_d   = slope_cnt_q;
    duty_d        = duty_q;
    dir_d         = dir_q;
    hold_d        = hold_q;
    trav_d        = trav_q;
    goal_cm_d     = goal_cm_q;
    done_d        = done_q;
    case (item_i.mode)
      MODE_PULSE: begin
        if (dir_q == DIR_FWD) begin
          pulse_count_d = pc_fwd;
          if (step_fwd) begin
            mark_d = mark_q + {8'd0, cfg_i.pulses_per_cm};
            trav_d = trav_fwd;
            if (arrive_fwd) begin
              done_d = 1'b1;
              dir_d  = DIR_STOP;
              hold_d = 1'b0;
            end
          end
        end else if (dir_q == DIR_REV) begin
          pulse_count_d = pc_rev;
          if (step_rev) begin
            mark_d = mark_q - {8'd0, cfg_i.pulses_per_cm};
            trav_d = trav_rev;
            if (arrive_rev) begin
              done_d = 1'b1;
              dir_d  = DIR_STOP;
              hold_d = 1'b0;
            end
          end
        end
      end
      MODE_SPEED_TICK: begin
        samples_d[0] = new_s0;
        samples_d[1] = new_s1;
        slot_d       = ~slot_q;
        last_pulse_d = pulse_count_q;
        avg_d        = avg_new;
        if (!hold_q) begin
          if (setpoint_q == 8'd0) begin
            duty_d = 8'd0;
            hold_d = 1'b1;
          end else if (avg_new > setpoint_q) begin
            if ($signed(duty_dn) < $signed({2'b00, cfg_i.pwm_floor})) begin
              duty_d = cfg_i.pwm_floor;
            end else begin
              duty_d = duty_dn[7:0];
            end
          end else if (avg_new < setpoint_q) begin
            if (duty_up > {1'b0, cfg_i.pwm_ceiling}) begin
              duty_d = cfg_i.pwm_ceiling;
            end else begin
              duty_d = duty_up[7:0];
            end
          end
        end else begin
          duty_d = 8'd0;
        end
      end
      MODE_RAMP_TICK: begin
        if (setpoint_q != goal_speed_q) begin
          if (slope_cnt_q >= slope_limit_q) begin
            slope_cnt_d = 8'd0;
            setpoint_d  = (setpoint_q > goal_speed_q) ? setpoint_q - 8'd1
                                                      : setpoint_q + 8'd1;
          end else begin
            slope_cnt_d = slope_cnt_q + 8'd1;
          end
        end
      end
      MODE_MOVE: begin
        done_d        = 1'b0;
        pulse_count_d = 16'd0;
        last_pulse_d  = 16'd0;
        mark_d        = 16'd0;
        slope_limit_d = item_i.ramp_slope;
        if (item_i.direction == DIR_FWD || item_i.direction == DIR_REV) begin
          if (!dir_match || hold_q) duty_d = cfg_i.start_pwm;
          dir_d  = dir_e'(item_i.direction);
          hold_d = 1'b0;
        end else begin
          dir_d  = DIR_STOP;
          hold_d = 1'b0;
        end
        setpoint_d   = item_i.start_speed;
        goal_speed_d = item_i.end_speed;
      end
      MODE_SET_DIST: begin
        goal_cm_d = item_i.target_cm;
        trav_d    = 16'd0;
      end
      MODE_NUDGE_UP: begin
        if (goal_speed_q < cfg_i.end_speed_max) goal_speed_d = goal_speed_q + 8'd1;
      end
      MODE_NUDGE_DOWN: begin
        if (goal_speed_q > cfg_i.end_speed_min) goal_speed_d = goal_speed_q - 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_count_q <= 16'd0;
      last_pulse_q  <= 16'd0;
      mark_q        <= 16'd0;
      samples_q[0]  <= 8'd0;
      samples_q[1]  <= 8'd0;
      slot_q        <= 1'b0;
      avg_q         <= 8'd0;
      setpoint_q    <= 8'd0;
      goal_speed_q  <= 8'd0;
      slope_limit_q <= 8'd0;
      slope_cnt_q   <= 8'd0;
      duty_q        <= 8'd0;
      dir_q         <= DIR_STOP;
      hold_q        <= 1'b0;
      trav_q        <= 16'd0;
      goal_cm_q     <= 16'd0;
      done_q        <= 1'b0;
    end else if (fire_i) begin
      pulse_count_q <= pulse_count_d;
      last_pulse_q  <= last_pulse_d;
      mark_q        <= mark_d;
      samples_q[0]  <= samples_d[0];
      samples_q[1]  <= samples_d[1];
      slot_q        <= slot_d;
      avg_q         <= avg_d;
      setpoint_q    <= setpoint_d;
      goal_speed_q  <= goal_speed_d;
      slope_limit_q <= slope_limit_d;
      slope_cnt_q   <= slope_cnt_d;
      duty_q        <= duty_d;
      dir_q         <= dir_d;
      hold_q        <= hold_d;
      trav_q        <= trav_d;
      goal_cm_q     <= goal_cm_d;
      done_q        <= done_d;
    end
  end

  always_comb begin
    result_o.pwm_duty       = duty_d;
    result_o.pwm_on         = (dir_d != DIR_STOP) && !hold_d;
    result_o.arrived        = done_d;
    result_o.direction_now  = dir_d;
    result_o.distance_cm    = trav_d;
    result_o.measured_speed = avg_d;
    result_o.speed_setpoint = setpoint_d;
  end

  // held wheel always has zero duty
  a_hold_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> duty_q == 8'd0)
    else $error("duty nonzero while held");

  // arrival always leaves the wheel stopped
  a_arrive_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> dir_q == DIR_STOP && !hold_q)
    else $error("arrived without stopping");

  a_slot_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.mode == MODE_SPEED_TICK |=> slot_q != $past(slot_q))
    else $error("sample slot did not alternate");

  a_ramp_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.mode == MODE_RAMP_TICK && setpoint_q == goal_speed_q
      |=> $stable(setpoint_q) && $stable(slope_cnt_q))
    else $error("ramp moved a settled setpoint");

endmodule

// ===== rtl/wheel_odometry_speed_controller_unit.sv =====
// Top level of the wheel odometry speed controller: stream ports, item and result registers.
// Depends on wosc_pkg, wosc_cfg_regs and wosc_core.
//
// Takes one item per clock while the output side is not stalled and returns exactly one
// result item for each, in order, through the input register and then the result
// register. An item is latched in the input register, applied to the controller state
// by a combinational update, and the resulting status is held in the result register; a
// stalled output keeps one item parked in the input register before back-pressure
// reaches s_axis_tready. The item kind travels on s_axis_tuser. Configuration writes
// take effect at the clock edge where cfg_we_i is high and are meant to be done with
// the block idle.
module wheel_odometry_speed_controller_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // direction[1:0], start_speed[9:2], end_speed[17:10], ramp_slope[25:18],
  // target_cm[41:26], zero fill
  input  logic [wosc_pkg::ItemDataW-1:0]   s_axis_tdata,
  // mode[2:0]
  input  logic [wosc_pkg::ItemUserW-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pwm_duty[7:0], pwm_on[8], arrived[9], direction_now[11:10], distance_cm[27:12],
  // measured_speed[35:28], speed_setpoint[43:36], zero fill
  output logic [wosc_pkg::ResultDataW-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [wosc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wosc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import wosc_pkg::*;

  cfg_t    cfg;
  item_t   item_in, item_q;
  result_t result, result_q;
  logic    in_valid_q, out_valid_q;
  logic    advance, fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    item_in.mode        = mode_e'(s_axis_tuser);
    item_in.direction   = s_axis_tdata[1:0];
    item_in.start_speed = s_axis_tdata[9:2];
    item_in.end_speed   = s_axis_tdata[17:10];
    item_in.ramp_slope  = s_axis_tdata[25:18];
    item_in.target_cm   = s_axis_tdata[41:26];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance)       out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_q <= item_in;
    if (fire) result_q <= result;
  end

  wosc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  wosc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0,
                          result_q.speed_setpoint,
                          result_q.measured_speed,
                          result_q.distance_cm,
                          result_q.direction_now,
                          result_q.arrived,
                          result_q.pwm_on,
                          result_q.pwm_duty};

endmodule

// ===== dv/wheel_odometry_speed_controller_unit_tb.sv =====
// Testbench for wheel_odometry_speed_controller_unit: directed table, then random phases
// with sender/receiver idling, checked item by item against a local wheel state predictor.
// Depends on wosc_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module wheel_odometry_speed_controller_unit_tb;
  import wosc_pkg::*;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam logic [1:0] DIR_SPARE  = 2'd3;
  localparam result_t    IDLE_STATUS = '0;
  localparam int         NUM_ROWS = 27;
  localparam int         ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  dir;
    logic [7:0]  start_spd;
    logic [7:0]  end_spd;
    logic [7:0]  slope;
    logic [15:0] target;
  } wheel_cmd_t;

  typedef struct packed {
    wheel_cmd_t cmd;
    logic       typed;
    result_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [ItemDataW-1:0]   s_axis_tdata = '0;
  logic [ItemUserW-1:0]   s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [ResultDataW-1:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_pressure = 1'b0;
  int          mismatches = 0;

  result_t pending_status[$];

  // wheel state as seen by the predictor
  cfg_t        wheel_regs;
  logic [15:0] w_pcnt, w_pcnt_last, w_mark, w_trav, w_goal_cm;
  logic [7:0]  w_samples [2];
  logic        w_slot, w_held, w_done;
  logic [7:0]  w_avg, w_sp, w_goal_spd, w_slope_lim, w_slope_cnt, w_duty;
  logic [1:0]  w_dir;

  row_t directed_rows [NUM_ROWS] = '{
    '{'{MODE_SPARE, DIR_SPARE, 8'd255, 8'd255, 8'd255, 16'hFFFF}, 1'b1, IDLE_STATUS},
    '{'{MODE_PULSE, DIR_SPARE, 8'd255, 8'd0, 8'd255, 16'h5555}, 1'b1, IDLE_STATUS},
    '{'{MODE_SPEED_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b1, IDLE_STATUS},
    '{'{MODE_NUDGE_UP, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b1, IDLE_STATUS},
    '{'{MODE_NUDGE_DOWN, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b1, IDLE_STATUS},
    '{'{MODE_MOVE, DIR_FWD, 8'd10, 8'd20, 8'd0, 16'h0000}, 1'b1,
      '{8'd64, 1'b1, 1'b0, DIR_FWD, 16'sd0, 8'd0, 8'd10}},
    '{'{MODE_SET_DIST, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0001}, 1'b1,
      '{8'd64, 1'b1, 1'b0, DIR_FWD, 16'sd0, 8'd0, 8'd10}},
    '{'{MODE_PULSE, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'd64, 1'b0, 1'b1, DIR_STOP, 16'sd1, 8'd0, 8'd10}},
    '{'{MODE_SPEED_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_RAMP_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_MOVE, DIR_REV, 8'd0, 8'd5, 8'd1, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SET_DIST, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'hFFFF}, 1'b0, IDLE_STATUS},
    '{'{MODE_PULSE, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_RAMP_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_RAMP_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_MOVE, DIR_SPARE, 8'd200, 8'd200, 8'd255, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SPEED_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_MOVE, DIR_FWD, 8'd0, 8'd0, 8'd255, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SPEED_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'd0, 1'b0, 1'b0, DIR_FWD, -16'sd1, 8'd0, 8'd0}},
    '{'{MODE_PULSE, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SET_DIST, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h7FFF}, 1'b0, IDLE_STATUS},
    '{'{MODE_MOVE, DIR_FWD, 8'd255, 8'd255, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_PULSE, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_PULSE, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SPEED_TICK, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS},
    '{'{MODE_SET_DIST, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h8000}, 1'b0, IDLE_STATUS},
    '{'{MODE_NUDGE_DOWN, DIR_STOP, 8'd0, 8'd0, 8'd0, 16'h0000}, 1'b0, IDLE_STATUS}
  };

  wheel_odometry_speed_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("[wheel_odometry_speed_controller_unit] ERROR");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic int as_signed16(input logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int duty_step(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] gap;
    gap = hi - lo;
    return (gap > 8'd3) ? 4 : int'(gap == 8'd0 ? 8'd1 : gap);
  endfunction

  function automatic void wheel_reset();
    wheel_regs = '{PulsesPerCmRst, PwmFloorRst, PwmCeilingRst, StartPwmRst,
                   EndSpeedMaxRst, EndSpeedMinRst};
    w_pcnt = '0; w_pcnt_last = '0; w_mark = '0; w_trav = '0; w_goal_cm = '0;
    w_samples[0] = '0; w_samples[1] = '0;
    w_slot = 1'b0; w_held = 1'b0; w_done = 1'b0;
    w_avg = '0; w_sp = '0; w_goal_spd = '0; w_slope_lim = '0; w_slope_cnt = '0;
    w_duty = '0; w_dir = DIR_STOP;
  endfunction

  function automatic void wheel_pulse();
    int ppc;
    ppc = int'(wheel_regs.pulses_per_cm);
    if (w_dir == DIR_FWD) begin
      w_pcnt = w_pcnt + 16'd1;
      if (as_signed16(w_pcnt - w_mark) >= ppc) begin
        w_mark = w_mark + 16'(ppc);
        w_trav = w_trav + 16'd1;
        if (as_signed16(w_goal_cm) <= as_signed16(w_trav)) begin
          w_done = 1'b1; w_dir = DIR_STOP; w_held = 1'b0;
        end
      end
    end else if (w_dir == DIR_REV) begin
      w_pcnt = w_pcnt - 16'd1;
      if (as_signed16(w_pcnt - w_mark) <= -ppc) begin
        w_mark = w_mark - 16'(ppc);
        w_trav = w_trav - 16'd1;
        if (as_signed16(w_goal_cm) >= as_signed16(w_trav)) begin
          w_done = 1'b1; w_dir = DIR_STOP; w_held = 1'b0;
        end
      end
    end
  endfunction

  function automatic void wheel_speed_tick();
    int delta;
    int nd;
    delta = as_signed16(w_pcnt - w_pcnt_last);
    if (!w_held && w_dir == DIR_FWD) begin
      if (delta >= 0) w_samples[w_slot] = (delta > 255) ? 8'd255 : 8'(delta);
    end else if (!w_held && w_dir == DIR_REV) begin
      if (delta <= 0) w_samples[w_slot] = (-delta > 255) ? 8'd255 : 8'(-delta);
    end else begin
      w_samples[w_slot] = '0;
    end
    w_slot = ~w_slot;
    w_pcnt_last = w_pcnt;
    w_avg = 8'((int'(w_samples[0]) + int'(w_samples[1])) >> 1);
    if (w_held) begin
      w_duty = '0;
    end else if (w_sp == 8'd0) begin
      w_duty = '0;
      w_held = 1'b1;
    end else if (w_avg > w_sp) begin
      nd = int'(w_duty) - duty_step(w_avg, w_sp);
      if (nd < int'(wheel_regs.pwm_floor)) nd = int'(wheel_regs.pwm_floor);
      w_duty = 8'(nd);
    end else if (w_avg < w_sp) begin
      nd = int'(w_duty) + duty_step(w_sp, w_avg);
      if (nd > int'(wheel_regs.pwm_ceiling)) nd = int'(wheel_regs.pwm_ceiling);
      w_duty = 8'(nd);
    end
  endfunction

  function automatic void predict_status(input wheel_cmd_t c, output result_t r);
    case (c.op)
      MODE_PULSE:      wheel_pulse();
      MODE_SPEED_TICK: wheel_speed_tick();
      MODE_RAMP_TICK: begin
        if (w_sp != w_goal_spd) begin
          if (w_slope_cnt >= w_slope_lim) begin
            w_slope_cnt = '0;
            w_sp = (w_sp > w_goal_spd) ? w_sp - 8'd1 : w_sp + 8'd1;
          end else begin
            w_slope_cnt = w_slope_cnt + 8'd1;
          end
        end
      end
      MODE_MOVE: begin
        w_done = 1'b0;
        w_pcnt = '0; w_pcnt_last = '0; w_mark = '0;
        w_slope_lim = c.slope;
        if (c.dir == DIR_FWD || c.dir == DIR_REV) begin
          if (w_dir != c.dir || w_held) w_duty = wheel_regs.start_pwm;
          w_dir = c.dir;
        end else begin
          w_dir = DIR_STOP;
        end
        w_held = 1'b0;
        w_sp = c.start_spd;
        w_goal_spd = c.end_spd;
      end
      MODE_SET_DIST: begin
        w_goal_cm = c.target;
        w_trav = '0;
      end
      MODE_NUDGE_UP:   if (w_goal_spd < wheel_regs.end_speed_max) w_goal_spd++;
      MODE_NUDGE_DOWN: if (w_goal_spd > wheel_regs.end_speed_min) w_goal_spd--;
      default: ;
    endcase
    r.pwm_duty       = w_duty;
    r.pwm_on         = (w_dir != DIR_STOP) && !w_held;
    r.arrived        = w_done;
    r.direction_now  = w_dir;
    r.distance_cm    = w_trav;
    r.measured_speed = w_avg;
    r.speed_setpoint = w_sp;
  endfunction

  // ---------------- checking ----------------

  task automatic note_error(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) note_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_status.size() == 0) begin
        note_error($sformatf("result item %h with nothing expected", m_axis_tdata));
      end else begin
        want = pending_status.pop_front();
        check_field("pwm_duty", m_axis_tdata[7:0], want.pwm_duty);
        check_field("pwm_on", m_axis_tdata[8], want.pwm_on);
        check_field("arrived", m_axis_tdata[9], want.arrived);
        check_field("direction_now", m_axis_tdata[11:10], want.direction_now);
        check_field("distance_cm", int'($signed(m_axis_tdata[27:12])),
                    int'(want.distance_cm));
        check_field("measured_speed", m_axis_tdata[35:28], want.measured_speed);
        check_field("speed_setpoint", m_axis_tdata[43:36], want.speed_setpoint);
      end
    end
  end

  // ---------------- receiver ----------------

  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      // long hold-off so the block backs up into s_axis_tready
      if (rx_pressure && (rx_cycle % 200) < 150) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // ---------------- sender ----------------

  task automatic send_item(input wheel_cmd_t c, input logic typed, input result_t typed_val);
    result_t predicted;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, c.target, c.slope, c.end_spd, c.start_spd, c.dir};
    s_axis_tuser  <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_status(c, predicted);
    pending_status.push_back(typed ? typed_val : predicted);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic load_regs(input cfg_t v);
    put_reg(CFG_PULSES_PER_CM, v.pulses_per_cm);
    put_reg(CFG_PWM_FLOOR, v.pwm_floor);
    put_reg(CFG_PWM_CEILING, v.pwm_ceiling);
    put_reg(CFG_START_PWM, v.start_pwm);
    put_reg(CFG_END_SPEED_MAX, v.end_speed_max);
    put_reg(CFG_END_SPEED_MIN, v.end_speed_min);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wheel_regs = v;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cfg_t phase_regs(input int p);
    cfg_t v;
    case (p)
      1: v = '{8'd1, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0};
      2: v = '{8'd3, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255};
      3: v = '{8'd255, PwmFloorRst, PwmCeilingRst, StartPwmRst, EndSpeedMaxRst,
               EndSpeedMinRst};
      default: v = '{8'($urandom_range(1, 6)), 8'($urandom_range(0, 60)),
                     8'($urandom_range(150, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(10, 255)), 8'($urandom_range(0, 10))};
    endcase
    return v;
  endfunction

  function automatic wheel_cmd_t random_cmd(input logic [2:0] op);
    wheel_cmd_t c;
    int r;
    c.op        = op;
    c.dir       = 2'($urandom_range(0, 3));
    c.start_spd = 8'($urandom);
    c.end_spd   = 8'($urandom);
    c.slope     = 8'($urandom);
    c.target    = 16'($urandom);
    if (op == MODE_MOVE) begin
      r = $urandom_range(0, 99);
      c.dir = (r < 8) ? DIR_STOP : (r < 12) ? DIR_SPARE : (r < 56) ? DIR_FWD : DIR_REV;
      if ($urandom_range(0, 3) != 0) begin
        c.start_spd = 8'($urandom_range(0, 24));
        c.end_spd   = 8'($urandom_range(0, 24));
        c.slope     = 8'($urandom_range(0, 3));
      end
    end
    if (op == MODE_SET_DIST && $urandom_range(0, 7) != 0) begin
      c.target = 16'($urandom_range(0, 12));
      if ($urandom_range(0, 1) != 0) c.target = -c.target;
    end
    return c;
  endfunction

  // pulse bursts between ticks and commands, now and then long enough to saturate
  task automatic random_phase(input int n_items);
    int sent;
    int burst;
    int r;
    logic [2:0] op;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 99) == 0) ? $urandom_range(256, 280) : $urandom_range(0, 8);
      repeat (burst) send_item(random_cmd(MODE_PULSE), 1'b0, IDLE_STATUS);
      r = $urandom_range(0, 99);
      op = (r < 35) ? MODE_SPEED_TICK : (r < 60) ? MODE_RAMP_TICK :
           (r < 72) ? MODE_MOVE : (r < 82) ? MODE_SET_DIST :
           (r < 89) ? MODE_NUDGE_UP : (r < 96) ? MODE_NUDGE_DOWN : MODE_SPARE;
      send_item(random_cmd(op), 1'b0, IDLE_STATUS);
      sent += burst + 1;
    end
  endtask

  initial begin
    wheel_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_regs('{8'd1, PwmFloorRst, PwmCeilingRst, StartPwmRst, EndSpeedMaxRst,
                EndSpeedMinRst});
    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 1; p <= 5; p++) begin
      settle();
      load_regs(phase_regs(p));
      tx_idle_pct  = (p == 2) ? 60 : (p == 4) ? 22 : 0;
      rx_stall_pct = (p == 3) ? 60 : (p == 4) ? 22 : 0;
      rx_pressure  = (p == 5);
      random_phase(ITEMS_PER_PHASE);
    end
    settle();

    if (mismatches == 0) $display("[wheel_odometry_speed_controller_unit] OK");
    else $display("[wheel_odometry_speed_controller_unit] ERROR");
    $finish;
  end

endmodule
